// ===== sv/sorted_free_list_pool_allocator_top_assert.svh =====
// Assertion macros used by the pool allocator checker.
`ifndef SORTED_FREE_LIST_POOL_ALLOCATOR_TOP_ASSERT_SVH
`define SORTED_FREE_LIST_POOL_ALLOCATOR_TOP_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define SFL_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define SFL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/sfl_pkg.sv =====
// Types, codes and helper functions of the pool allocator.
`timescale 1ns / 1ps
package sfl_pkg;

    // Field widths of the request and response beats
    localparam int CMD_W     = 1;
    localparam int POOL_ID_W = 2;
    localparam int REQ_W     = 13;
    localparam int CHUNK_W   = 6;
    localparam int STATUS_W  = 2;
    localparam int OFFSET_W  = 18;

    // Chunk sizing
    localparam logic [REQ_W-1:0] MIN_REQUEST = REQ_W'(1);
    localparam logic [REQ_W-1:0] MAX_REQUEST = REQ_W'(4096);
    localparam logic [REQ_W-1:0] ALIGN_M1    = REQ_W'(31);

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC   = 1'b0,
        CMD_RELEASE = 1'b1
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FREE  = 2'd2
    } t_status;

    // Link memory write sources
    typedef enum logic [2:0] {
        WR_NONE,
        WR_INIT,
        WR_C_END,
        WR_C_HEAD,
        WR_PREV_C,
        WR_C_V
    } t_wr_sel;

    // Link memory read address sources
    typedef enum logic {
        RD_HEAD,
        RD_NEXT
    } t_rd_sel;

    // Free list head updates
    typedef enum logic [1:0] {
        HD_NONE,
        HD_CHUNK,
        HD_LINK,
        HD_START
    } t_hd_sel;

    // Controller to datapath
    typedef struct packed {
        logic    cap;
        logic    cnt_clr;
        logic    cnt_inc;
        logic    walk_clr;
        logic    walk_adv;
        logic    save_v;
        logic    grant;
        logic    st_load;
        t_status st_code;
        logic    out_load;
        t_wr_sel wr_sel;
        t_rd_sel rd_sel;
        t_hd_sel hd_sel;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic is_release;
        logic pool_bad;
        logic started;
        logic chunk_bad;
        logic head_end;
        logic chunk_eq_head;
        logic chunk_lt_head;
        logic init_last;
        logic walk_go;
        logic walk_hit;
        logic out_free;
    } t_dp_stat;

    // Clamp the request to 1..4096 and round it up to a multiple of 32 bytes
    function automatic logic [REQ_W-1:0] f_round_chunk(input logic [REQ_W-1:0] req);
        logic [REQ_W-1:0] r;
        if (req == '0) begin
            r = MIN_REQUEST;
        end else if (req > MAX_REQUEST) begin
            r = MAX_REQUEST;
        end else begin
            r = req;
        end
        return REQ_W'(r + ALIGN_M1) & ~ALIGN_M1;
    endfunction

endpackage

// ===== sv/sfl_if.sv =====
// Request and response channel interfaces of the pool allocator.
`timescale 1ns / 1ps
interface sfl_in_if;
    logic                            valid;
    logic                            ready;
    logic [sfl_pkg::CMD_W-1:0]       cmd;
    logic [sfl_pkg::POOL_ID_W-1:0]   pool_id;
    logic [sfl_pkg::REQ_W-1:0]       request_size;
    logic [sfl_pkg::CHUNK_W-1:0]     chunk_index;

    modport source (output valid, cmd, pool_id, request_size, chunk_index, input ready);
    modport sink (input valid, cmd, pool_id, request_size, chunk_index, output ready);
endinterface

interface sfl_out_if;
    logic                            valid;
    logic                            ready;
    logic [sfl_pkg::STATUS_W-1:0]    status;
    logic [sfl_pkg::CHUNK_W-1:0]     granted_chunk;
    logic [sfl_pkg::OFFSET_W-1:0]    byte_offset;

    modport source (output valid, status, granted_chunk, byte_offset, input ready);
    modport sink (input valid, status, granted_chunk, byte_offset, output ready);
endinterface

// ===== sv/sfl_ram.sv =====
// Generic single write port, single read port RAM with registered read.
`timescale 1ns / 1ps
module sfl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/sfl_ctrl.sv =====
// Controller state machine of the pool allocator.
`timescale 1ns / 1ps
module sfl_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  sfl_pkg::t_dp_stat i_stat,
    output sfl_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_INIT,
        S_ALLOC,
        S_WALK,
        S_LINK,
        S_RESULT
    } t_state;

    t_state r_state, n_state;
    logic   r_in_ready;
    sfl_pkg::t_dp_cmd cmd;

    // Next state and datapath commands
    always_comb begin
        n_state      = r_state;
        cmd          = '0;
        cmd.st_code  = sfl_pkg::ST_OK;
        cmd.wr_sel   = sfl_pkg::WR_NONE;
        cmd.rd_sel   = sfl_pkg::RD_HEAD;
        cmd.hd_sel   = sfl_pkg::HD_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && r_in_ready) begin
                    cmd.cap = 1'b1;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (!i_stat.is_release) begin
                    priority if (i_stat.pool_bad || (i_stat.started && i_stat.head_end)) begin
                        cmd.st_load = 1'b1;
                        cmd.st_code = sfl_pkg::ST_EMPTY;
                        n_state     = S_RESULT;
                    end else if (!i_stat.started) begin
                        cmd.cnt_clr = 1'b1;
                        n_state     = S_INIT;
                    end else begin
                        cmd.rd_sel = sfl_pkg::RD_HEAD;
                        n_state    = S_ALLOC;
                    end
                end else begin
                    priority if (i_stat.pool_bad || !i_stat.started || i_stat.chunk_bad) begin
                        cmd.st_load = 1'b1;
                        cmd.st_code = sfl_pkg::ST_FREE;
                        n_state     = S_RESULT;
                    end else if (i_stat.head_end) begin
                        cmd.wr_sel  = sfl_pkg::WR_C_END;
                        cmd.hd_sel  = sfl_pkg::HD_CHUNK;
                        cmd.st_load = 1'b1;
                        cmd.st_code = sfl_pkg::ST_OK;
                        n_state     = S_RESULT;
                    end else if (i_stat.chunk_eq_head) begin
                        cmd.st_load = 1'b1;
                        cmd.st_code = sfl_pkg::ST_FREE;
                        n_state     = S_RESULT;
                    end else if (i_stat.chunk_lt_head) begin
                        cmd.wr_sel  = sfl_pkg::WR_C_HEAD;
                        cmd.hd_sel  = sfl_pkg::HD_CHUNK;
                        cmd.st_load = 1'b1;
                        cmd.st_code = sfl_pkg::ST_OK;
                        n_state     = S_RESULT;
                    end else begin
                        cmd.rd_sel   = sfl_pkg::RD_HEAD;
                        cmd.walk_clr = 1'b1;
                        n_state      = S_WALK;
                    end
                end
            end
            S_INIT: begin
                cmd.wr_sel  = sfl_pkg::WR_INIT;
                cmd.cnt_inc = 1'b1;
                if (i_stat.init_last) begin
                    cmd.hd_sel = sfl_pkg::HD_START;
                    n_state    = S_CHECK;
                end
            end
            S_ALLOC: begin
                cmd.hd_sel  = sfl_pkg::HD_LINK;
                cmd.grant   = 1'b1;
                cmd.st_load = 1'b1;
                cmd.st_code = sfl_pkg::ST_OK;
                n_state     = S_RESULT;
            end
            S_WALK: begin
                priority if (i_stat.walk_go) begin
                    cmd.walk_adv = 1'b1;
                    cmd.rd_sel   = sfl_pkg::RD_NEXT;
                end else if (i_stat.walk_hit) begin
                    cmd.st_load = 1'b1;
                    cmd.st_code = sfl_pkg::ST_FREE;
                    n_state     = S_RESULT;
                end else begin
                    cmd.wr_sel = sfl_pkg::WR_PREV_C;
                    cmd.save_v = 1'b1;
                    n_state    = S_LINK;
                end
            end
            S_LINK: begin
                cmd.wr_sel  = sfl_pkg::WR_C_V;
                cmd.st_load = 1'b1;
                cmd.st_code = sfl_pkg::ST_OK;
                n_state     = S_RESULT;
            end
            S_RESULT: begin
                if (i_stat.out_free) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered ready
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_ready <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_in_ready <= (n_state == S_IDLE);
        end
    end

    assign o_in_ready = r_in_ready;
    assign o_cmd      = cmd;

endmodule

// ===== sv/sfl_dp.sv =====
// Datapath of the pool allocator: pool registers, link memory, walk and output registers.
`timescale 1ns / 1ps
module sfl_dp #(
    parameter int POOL_COUNT      = 4,
    parameter int CHUNKS_PER_POOL = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  sfl_pkg::t_dp_cmd                i_cmd,
    output sfl_pkg::t_dp_stat               o_stat,
    input  logic [sfl_pkg::CMD_W-1:0]       i_req_cmd,
    input  logic [sfl_pkg::POOL_ID_W-1:0]   i_pool_id,
    input  logic [sfl_pkg::REQ_W-1:0]       i_request_size,
    input  logic [sfl_pkg::CHUNK_W-1:0]     i_chunk_index,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output logic [sfl_pkg::STATUS_W-1:0]    o_status,
    output logic [sfl_pkg::CHUNK_W-1:0]     o_granted_chunk,
    output logic [sfl_pkg::OFFSET_W-1:0]    o_byte_offset
);

    // Link values run 0..CHUNKS_PER_POOL, the top value ends a list
    localparam int LW    = $clog2(CHUNKS_PER_POOL + 1);
    localparam int PW    = (POOL_COUNT > 1) ? $clog2(POOL_COUNT) : 1;
    localparam int DEPTH = POOL_COUNT * CHUNKS_PER_POOL;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [LW-1:0] END_L = LW'(CHUNKS_PER_POOL);

    // Captured request
    logic [sfl_pkg::CMD_W-1:0]     r_cmd;
    logic [sfl_pkg::POOL_ID_W-1:0] r_pool;
    logic [sfl_pkg::REQ_W-1:0]     r_req;
    logic [sfl_pkg::CHUNK_W-1:0]   r_chunk;

    // Per-pool state
    logic [LW-1:0]               r_head    [POOL_COUNT];
    logic                        r_started [POOL_COUNT];
    logic [sfl_pkg::REQ_W-1:0]   r_bytes   [POOL_COUNT];

    // Work registers
    logic [LW-1:0]                 r_cnt;
    logic [LW-1:0]                 r_steps;
    logic [LW-1:0]                 r_prev;
    logic [LW-1:0]                 r_v;
    logic [LW-1:0]                 r_gr;
    logic [sfl_pkg::OFFSET_W-1:0]  r_offset;
    sfl_pkg::t_status              r_status;

    // Output register
    logic                            r_o_valid;
    logic [sfl_pkg::STATUS_W-1:0]    r_o_status;
    logic [sfl_pkg::CHUNK_W-1:0]     r_o_granted;
    logic [sfl_pkg::OFFSET_W-1:0]    r_o_offset;

    logic [PW-1:0]  idx;
    logic [LW-1:0]  chunk_l;
    logic [LW-1:0]  head;
    logic [LW-1:0]  v;
    logic           pool_bad;
    logic           chunk_bad;
    logic           grant_ok;
    logic           ram_we;
    logic [AW-1:0]  ram_waddr;
    logic [LW-1:0]  ram_wdata;
    logic [AW-1:0]  ram_raddr;
    logic [LW-1:0]  ram_rdata;

    function automatic logic [AW-1:0] f_addr(input logic [PW-1:0] p, input logic [LW-1:0] c);
        return AW'(32'(p) * CHUNKS_PER_POOL + 32'(c));
    endfunction

    // Request decode
    assign idx       = PW'(r_pool);
    assign chunk_l   = LW'(r_chunk);
    assign pool_bad  = (32'(r_pool) >= 32'(POOL_COUNT));
    assign chunk_bad = (32'(r_chunk) >= 32'(CHUNKS_PER_POOL));
    assign head      = r_head[idx];
    // Out-of-range links count as end of list
    assign v         = (ram_rdata >= END_L) ? END_L : ram_rdata;

    always_comb begin
        o_stat.is_release    = (r_cmd == sfl_pkg::CMD_RELEASE);
        o_stat.pool_bad      = pool_bad;
        o_stat.started       = r_started[idx];
        o_stat.chunk_bad     = chunk_bad;
        o_stat.head_end      = (head >= END_L);
        o_stat.chunk_eq_head = (chunk_l == head);
        o_stat.chunk_lt_head = (chunk_l < head);
        o_stat.init_last     = (r_cnt == LW'(CHUNKS_PER_POOL - 1));
        o_stat.walk_go       = (v < END_L) && (v < chunk_l) && (r_steps < END_L);
        o_stat.walk_hit      = (v == chunk_l);
        o_stat.out_free      = !r_o_valid || i_out_ready;
    end

    // Link memory write port
    always_comb begin
        ram_we    = 1'b1;
        ram_waddr = f_addr(idx, chunk_l);
        ram_wdata = END_L;
        unique case (i_cmd.wr_sel)
            sfl_pkg::WR_NONE: begin
                ram_we = 1'b0;
            end
            sfl_pkg::WR_INIT: begin
                ram_waddr = f_addr(idx, r_cnt);
                ram_wdata = LW'(r_cnt + LW'(1));
            end
            sfl_pkg::WR_C_END: begin
                ram_wdata = END_L;
            end
            sfl_pkg::WR_C_HEAD: begin
                ram_wdata = head;
            end
            sfl_pkg::WR_PREV_C: begin
                ram_waddr = f_addr(idx, r_prev);
                ram_wdata = chunk_l;
            end
            sfl_pkg::WR_C_V: begin
                ram_wdata = r_v;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    // Read the head's link, or chase the link just read
    assign ram_raddr = (i_cmd.rd_sel == sfl_pkg::RD_NEXT) ? f_addr(idx, v) : f_addr(idx, head);

    sfl_ram #(
        .WIDTH (LW),
        .DEPTH (DEPTH)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Per-pool head, start flag and chunk size
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < POOL_COUNT; p++) begin
                r_head[p]    <= '0;
                r_started[p] <= 1'b0;
                r_bytes[p]   <= '0;
            end
        end else begin
            unique case (i_cmd.hd_sel)
                sfl_pkg::HD_NONE: begin
                end
                sfl_pkg::HD_CHUNK: begin
                    r_head[idx] <= chunk_l;
                end
                sfl_pkg::HD_LINK: begin
                    r_head[idx] <= v;
                end
                sfl_pkg::HD_START: begin
                    r_head[idx]    <= '0;
                    r_started[idx] <= 1'b1;
                    r_bytes[idx]   <= sfl_pkg::f_round_chunk(r_req);
                end
                default: begin
                end
            endcase
        end
    end

    // Request capture, counters, walk and grant registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_cmd   <= i_req_cmd;
            r_pool  <= i_pool_id;
            r_req   <= i_request_size;
            r_chunk <= i_chunk_index;
        end
        if (i_cmd.cnt_clr) begin
            r_cnt <= '0;
        end else if (i_cmd.cnt_inc) begin
            r_cnt <= LW'(r_cnt + LW'(1));
        end
        if (i_cmd.walk_clr) begin
            r_prev  <= head;
            r_steps <= '0;
        end else if (i_cmd.walk_adv) begin
            r_prev  <= v;
            r_steps <= LW'(r_steps + LW'(1));
        end
        if (i_cmd.save_v) begin
            r_v <= v;
        end
        if (i_cmd.grant) begin
            r_gr     <= head;
            r_offset <= sfl_pkg::OFFSET_W'(32'(head) * 32'(r_bytes[idx]));
        end
        if (i_cmd.st_load) begin
            r_status <= i_cmd.st_code;
        end
    end

    // Grant fields read zero unless an allocate succeeded
    assign grant_ok = (r_status == sfl_pkg::ST_OK) && (r_cmd == sfl_pkg::CMD_ALLOC);

    // Response beat register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
        if (i_cmd.out_load) begin
            r_o_status  <= r_status;
            r_o_granted <= grant_ok ? sfl_pkg::CHUNK_W'(r_gr) : '0;
            r_o_offset  <= grant_ok ? r_offset : '0;
        end
    end

    assign o_out_valid     = r_o_valid;
    assign o_status        = r_o_status;
    assign o_granted_chunk = r_o_granted;
    assign o_byte_offset   = r_o_offset;

endmodule

// ===== sv/sorted_free_list_pool_allocator_top.sv =====
// Top level of the sorted free-list pool allocator.
`timescale 1ns / 1ps
// Usage:
//   i_req carries one request beat: cmd (allocate or release), pool_id,
//   request_size and chunk_index. o_rsp returns exactly one response beat per
//   request: status, granted_chunk and byte_offset. Both channels move a beat
//   when valid and ready are high at a rising clock edge.
// Sequencing:
//   An allocate from a started pool is checked, granted from the pool's head
//   and then loaded into the response; rejected requests skip the grant step.
//   The first allocate of a pool first chains all its chunks, one link
//   memory write a cycle, then checks the pool again. A release walks the
//   address-sorted free list one link per cycle through the registered read
//   port of the link memory, so it takes longer the further along the list
//   its chunk falls. One request is in flight at a time.
// Reset:
//   Synchronous, active low. All pools return to the unstarted state with
//   heads at zero; the link memory is not cleared, since a pool writes every
//   link when it starts. i_req.ready rises in the cycle after reset ends.
// Stalls:
//   The response sits in an output register until taken; the next request is
//   accepted meanwhile, and its response waits for the register to drain.
module sorted_free_list_pool_allocator_top #(
    parameter int POOL_COUNT      = 4,
    parameter int CHUNKS_PER_POOL = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sfl_in_if.sink     i_req,
    sfl_out_if.source  o_rsp
);

    sfl_pkg::t_dp_cmd  dp_cmd;
    sfl_pkg::t_dp_stat dp_stat;
    logic              in_ready;

    sfl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (in_ready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    sfl_dp #(
        .POOL_COUNT      (POOL_COUNT),
        .CHUNKS_PER_POOL (CHUNKS_PER_POOL)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (dp_cmd),
        .o_stat          (dp_stat),
        .i_req_cmd       (i_req.cmd),
        .i_pool_id       (i_req.pool_id),
        .i_request_size  (i_req.request_size),
        .i_chunk_index   (i_req.chunk_index),
        .i_out_ready     (o_rsp.ready),
        .o_out_valid     (o_rsp.valid),
        .o_status        (o_rsp.status),
        .o_granted_chunk (o_rsp.granted_chunk),
        .o_byte_offset   (o_rsp.byte_offset)
    );

    assign i_req.ready = in_ready;

endmodule

// ===== sv/sfl_checker.sv =====
// Port-level checker of the pool allocator and its bind.
`timescale 1ns / 1ps
`include "sorted_free_list_pool_allocator_top_assert.svh"
module sfl_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [sfl_pkg::STATUS_W-1:0]  i_status,
    input logic [sfl_pkg::CHUNK_W-1:0]   i_granted,
    input logic [sfl_pkg::OFFSET_W-1:0]  i_offset
);

    // A stalled response beat holds
    `SFL_ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_status) && $stable(i_granted) && $stable(i_offset), "stalled response changed")

    // Only defined status codes leave the block
    `SFL_ASSERT_SAME(a_status_code, i_clk, i_rst_n, i_out_valid, (i_status == sfl_pkg::ST_OK) || (i_status == sfl_pkg::ST_EMPTY) || (i_status == sfl_pkg::ST_FREE), "undefined status code")

    // Rejected requests carry no grant
    `SFL_ASSERT_SAME(a_reject_zero, i_clk, i_rst_n, i_out_valid && (i_status != sfl_pkg::ST_OK), (i_granted == '0) && (i_offset == '0), "grant fields set on a rejected request")

    // Offsets fall on 32-byte boundaries
    `SFL_ASSERT_SAME(a_offset_align, i_clk, i_rst_n, i_out_valid, i_offset[4:0] == 5'd0, "byte offset not 32-byte aligned")

    // One request in flight: ready drops after an accepted beat
    `SFL_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready, "request accepted while one is in flight")

endmodule

bind sorted_free_list_pool_allocator_top sfl_checker u_sfl_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_status    (o_rsp.status),
    .i_granted   (o_rsp.granted_chunk),
    .i_offset    (o_rsp.byte_offset)
);
